>>> rtl/lbcp_pkg.sv
// Shared types, constants and tables for the lidar beam to camera projection.
// No dependencies; every other file imports this package.
package lbcp_pkg;

   localparam int BEAMS_DEF = 360;

   // Angles in 2^-20 rad
   localparam int PI_Q      = 3294199;
   localparam int HALF_PI_Q = 1647099;
   localparam int TWO_PI_Q  = 6588397;
   // Reciprocal of two pi: floor(2^45 / TWO_PI_Q)
   localparam int RECIP_M   = 5340353;
   localparam int RECIP_S   = 45;

   localparam int KINV_Q30  = 652032874;
   localparam int COS_Q20   = 1001743;
   localparam int SIN_Q20   = 309875;
   localparam int OFF_Q16   = 13107;
   localparam int ITER      = 20;
   localparam int SAT_HI    = 32767;

   localparam int XW  = 27;   // cordic x and y
   localparam int AW  = 24;   // cordic residual angle
   localparam int PW  = XW + 21; // rotation products
   localparam int VW  = 28;   // camera coordinates
   localparam int NW  = 46;   // projection numerators
   localparam int DW  = 32;   // projection denominators
   localparam int QB  = 16;   // quotient bits
   localparam int DIV_LAT = QB + 2;

   typedef enum logic [3:0] {
      REG_START_ANGLE  = 4'd0,
      REG_ANGLE_STEP   = 4'd1,
      REG_FOCAL_LENGTH = 4'd2,
      REG_CENTER_X     = 4'd3,
      REG_CENTER_Y     = 4'd4,
      REG_IMAGE_WIDTH  = 4'd5,
      REG_IMAGE_HEIGHT = 4'd6,
      REG_MAX_RANGE    = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [AW-1:0] r;
      logic                 neg;
      logic                 view_rng;
   } cordic_type;

   function automatic logic signed [AW-1:0] atan_of(input int step);
      logic signed [AW-1:0] v;
      case (step)
         0: v = AW'(823550);
         1: v = AW'(486170);
         2: v = AW'(256879);
         3: v = AW'(130396);
         4: v = AW'(65451);
         5: v = AW'(32757);
         6: v = AW'(16383);
         7: v = AW'(8192);
         8: v = AW'(4096);
         9: v = AW'(2048);
         10: v = AW'(1024);
         11: v = AW'(512);
         12: v = AW'(256);
         13: v = AW'(128);
         14: v = AW'(64);
         15: v = AW'(32);
         16: v = AW'(16);
         17: v = AW'(8);
         18: v = AW'(4);
         19: v = AW'(2);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/lidar_beam_camera_projection.sv
// Lidar beam to camera pixel projection: angle reduction, 20-cell CORDIC chain,
// extrinsic rotation, and four pipelined dividers for the pinhole projection.
// One item per cycle sustained while req_stall is low.
// The whole pipeline advances together; it holds only when the output register
// waits on rsp_stall and the last stage also has an item.
// Synchronous reset empties the pipeline and loads the default registers.
module lidar_beam_camera_projection
   import lbcp_pkg::*;
#(
   parameter int BEAMS = BEAMS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [8:0]         req_beam_index,
   input  logic [15:0]        req_range_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_pixel_x,
   output logic signed [15:0] rsp_pixel_y,
   output logic signed [15:0] rsp_span_start,
   output logic signed [15:0] rsp_span_end,
   output logic               rsp_in_view,
   output logic               rsp_depth_positive,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [22:0]        csr_wdata
);

   localparam int HALF = BEAMS / 2;
   localparam int SW   = $clog2(511 + HALF + 1);
   localparam int TW   = SW + 19;
   localparam int QW   = TW - 23;
   localparam int MW   = TW - 1 + 23;
   localparam logic signed [PW-1:0] SIN_OFF = PW'(SIN_Q20) * PW'(OFF_Q16);
   localparam logic signed [PW-1:0] COS_OFF = PW'(COS_Q20) * PW'(OFF_Q16);

   // configuration
   logic signed [22:0] start_ff;
   logic [17:0] step_ff;
   logic [15:0] focal_ff, cx_ff, cy_ff, maxr_ff;
   logic [11:0] width_ff, height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= 23'(-3294199);
         step_ff   <= 18'd18300;
         focal_ff  <= 16'd7627;
         cx_ff     <= 16'd6408;
         cy_ff     <= 16'd6408;
         width_ff  <= 12'd200;
         height_ff <= 12'd200;
         maxr_ff   <= 16'd5120;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_START_ANGLE:  start_ff  <= csr_wdata;
            REG_ANGLE_STEP:   step_ff   <= csr_wdata[17:0];
            REG_FOCAL_LENGTH: focal_ff  <= csr_wdata[15:0];
            REG_CENTER_X:     cx_ff     <= csr_wdata[15:0];
            REG_CENTER_Y:     cy_ff     <= csr_wdata[15:0];
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[11:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata[11:0];
            REG_MAX_RANGE:    maxr_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic adv, last_valid, rsp_valid_ff;
   assign adv       = !(rsp_valid_ff && rsp_stall && last_valid);
   assign req_stall = !adv;

   // stage 0: beam angle
   logic v0_ff;
   logic signed [TW-1:0] theta_ff, theta_in;
   logic [15:0] rng0_ff;
   logic vr0_ff;
   logic [SW-1:0] bidx;

   always_comb begin
      bidx     = SW'(req_beam_index) + SW'(HALF);
      theta_in = $signed({1'b0, (TW-1)'(bidx) * (TW-1)'(step_ff)}) + TW'(start_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         theta_ff <= theta_in;
         rng0_ff  <= req_range_value;
         vr0_ff   <= req_range_value < maxr_ff;
      end
   end

   // stage 1: reciprocal product for the turn count, range gain product
   logic v1_ff, vr1_ff;
   logic signed [TW-1:0] theta1_ff;
   logic [MW-1:0] qp_ff;
   logic [45:0] xm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         theta1_ff <= theta_ff;
         qp_ff     <= theta_ff[TW-2:0] * 23'(RECIP_M);
         xm_ff     <= rng0_ff * 30'(KINV_Q30);
         vr1_ff    <= vr0_ff;
      end
   end

   // stage 2: remainder within two turns
   logic v2_ff, vr2_ff;
   logic signed [24:0] r0_ff;
   logic [23:0] x0_ff;
   logic [QW-1:0] qt;
   logic [TW-1:0] qd;
   logic signed [TW-1:0] r0;
   logic [45:0] xr;

   always_comb begin
      qt = qp_ff[RECIP_S +: QW];
      qd = TW'(qt) * TW'(TWO_PI_Q);
      if (theta1_ff < 0) begin
         r0 = theta1_ff + TW'(TWO_PI_Q);
      end else begin
         r0 = theta1_ff - $signed(qd);
      end
      xr = xm_ff + 46'(1 << 21);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r0_ff  <= r0[24:0];
         x0_ff  <= xr[45:22];
         vr2_ff <= vr1_ff;
      end
   end

   // stage 3: fold into the right half plane
   logic v3_ff;
   cordic_type c0_ff, c0_in;
   logic signed [24:0] r1, r2, r3;
   logic fneg;

   always_comb begin
      r1 = (r0_ff >= 25'(TWO_PI_Q)) ? r0_ff - 25'(TWO_PI_Q) : r0_ff;
      r2 = (r1 > 25'(PI_Q)) ? r1 - 25'(TWO_PI_Q) : r1;
      fneg = 1'b0;
      r3 = r2;
      if (r2 > 25'(HALF_PI_Q)) begin
         r3 = r2 - 25'(PI_Q);
         fneg = 1'b1;
      end else if (r2 < -25'(HALF_PI_Q)) begin
         r3 = r2 + 25'(PI_Q);
         fneg = 1'b1;
      end
      c0_in.x = XW'($signed({1'b0, x0_ff}));
      c0_in.y = '0;
      c0_in.r = r3[AW-1:0];
      c0_in.neg = fneg;
      c0_in.view_rng = vr2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c0_ff <= c0_in;
      end
   end

   // cordic chain
   logic       cv [0:ITER];
   cordic_type cd [0:ITER];
   assign cv[0] = v3_ff;
   assign cd[0] = c0_ff;

   for (genvar i = 0; i < ITER; i++) begin : g_cell
      lbcp_cordic_cell #(.STEP(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (cv[i]),
         .in_data   (cd[i]),
         .out_valid (cv[i+1]),
         .out_data  (cd[i+1])
      );
   end

   // post 1: rotation products
   logic p1v_ff, p1r_ff;
   logic signed [PW-1:0] cl_ff, sl_ff;
   logic signed [XW-1:0] lx_ff, lz, lx;

   always_comb begin
      lz = cd[ITER].neg ? -cd[ITER].x : cd[ITER].x;
      lx = cd[ITER].neg ? cd[ITER].y : -cd[ITER].y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1v_ff <= 1'b0;
      end else if (adv) begin
         p1v_ff <= cv[ITER];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cl_ff  <= PW'(lz) * PW'(COS_Q20);
         sl_ff  <= PW'(lz) * PW'(SIN_Q20);
         lx_ff  <= lx;
         p1r_ff <= cd[ITER].view_rng;
      end
   end

   // post 2: camera coordinates for the point and both span ends
   logic p2v_ff, p2r_ff;
   logic signed [VW-1:0] z0_ff, y0_ff, zs_ff, ys_ff, ze_ff, ye_ff, lx2_ff;
   logic signed [PW-1:0] t_z0, t_y0, t_zs, t_ys, t_ze, t_ye;

   always_comb begin
      t_z0 = cl_ff >>> 20;
      t_y0 = (-sl_ff) >>> 20;
      t_zs = (cl_ff - SIN_OFF) >>> 20;
      t_ys = (COS_OFF - sl_ff) >>> 20;
      t_ze = (cl_ff + SIN_OFF) >>> 20;
      t_ye = (-COS_OFF - sl_ff) >>> 20;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2v_ff <= 1'b0;
      end else if (adv) begin
         p2v_ff <= p1v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         z0_ff  <= VW'(t_z0);
         y0_ff  <= VW'(t_y0) - VW'(OFF_Q16);
         zs_ff  <= VW'(t_zs);
         ys_ff  <= VW'(t_ys) - VW'(OFF_Q16);
         ze_ff  <= VW'(t_ze);
         ye_ff  <= VW'(t_ye) - VW'(OFF_Q16);
         lx2_ff <= VW'(lx_ff);
         p2r_ff <= p1r_ff;
      end
   end

   // post 3: projection numerators and denominators
   logic p3v_ff;
   logic signed [NW-1:0] nx_ff, ny_ff, ns_ff, ne_ff;
   logic [DW-1:0] d0_ff, ds_ff, de_ff;
   logic f0_ff, fs_ff, fe_ff, p3r_ff;
   logic signed [16:0] fl, cxs, cys;
   logic dpos, spos, epos;

   function automatic logic signed [NW-1:0] proj(input logic signed [16:0] f,
                                                 input logic signed [VW-1:0] v,
                                                 input logic signed [16:0] c,
                                                 input logic signed [VW-1:0] z);
      logic signed [44:0] a, b;
      a = f * v;
      b = c * z;
      return NW'(a) + NW'(b);
   endfunction

   function automatic logic [DW-1:0] denom(input logic signed [VW-1:0] z);
      return (z > 0) ? {z[DW-5:0], 4'b0} : DW'(1);
   endfunction

   always_comb begin
      fl   = $signed({1'b0, focal_ff});
      cxs  = $signed({1'b0, cx_ff});
      cys  = $signed({1'b0, cy_ff});
      dpos = z0_ff > 0;
      spos = zs_ff > 0;
      epos = ze_ff > 0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3v_ff <= 1'b0;
      end else if (adv) begin
         p3v_ff <= p2v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff  <= proj(fl, lx2_ff, cxs, z0_ff);
         ny_ff  <= proj(fl, y0_ff, cys, z0_ff);
         ns_ff  <= proj(fl, ys_ff, cys, zs_ff);
         ne_ff  <= proj(fl, ye_ff, cys, ze_ff);
         d0_ff  <= denom(z0_ff);
         ds_ff  <= denom(zs_ff);
         de_ff  <= denom(ze_ff);
         f0_ff  <= !dpos;
         fs_ff  <= !dpos || !spos;
         fe_ff  <= !dpos || !epos;
         p3r_ff <= p2r_ff && dpos;
      end
   end

   // dividers, flags travel alongside
   logic signed [15:0] qx, qy, qs, qe;
   logic [1:0] tag_ff [0:DIV_LAT-1];

   lbcp_divider #(.FLOOR(1'b1)) u_div_x (
      .clock(clock), .reset(reset), .en(adv), .in_valid(p3v_ff),
      .num(nx_ff), .den(d0_ff), .force_max(f0_ff),
      .out_valid(last_valid), .quot(qx)
   );
   lbcp_divider #(.FLOOR(1'b1)) u_div_y (
      .clock(clock), .reset(reset), .en(adv), .in_valid(p3v_ff),
      .num(ny_ff), .den(d0_ff), .force_max(f0_ff),
      .out_valid(), .quot(qy)
   );
   lbcp_divider #(.FLOOR(1'b0)) u_div_s (
      .clock(clock), .reset(reset), .en(adv), .in_valid(p3v_ff),
      .num(ns_ff), .den(ds_ff), .force_max(fs_ff),
      .out_valid(), .quot(qs)
   );
   lbcp_divider #(.FLOOR(1'b0)) u_div_e (
      .clock(clock), .reset(reset), .en(adv), .in_valid(p3v_ff),
      .num(ne_ff), .den(de_ff), .force_max(fe_ff),
      .out_valid(), .quot(qe)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= {p3r_ff, !f0_ff};
         for (int k = 1; k < DIV_LAT; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   // output register
   logic signed [15:0] px_ff, py_ff, ss_ff, se_ff;
   logic view_ff, dpos_ff, view_in;
   logic signed [12:0] wlim, hlim;

   always_comb begin
      wlim = $signed({1'b0, width_ff}) - 13'sd2;
      hlim = $signed({1'b0, height_ff}) - 13'sd2;
      view_in = tag_ff[DIV_LAT-1][1] &&
                qx >= 16'sd2 && qx < 16'(wlim) &&
                qy >= 16'sd2 && qy < 16'(hlim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= last_valid || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (adv && last_valid) begin
         px_ff   <= qx;
         py_ff   <= qy;
         ss_ff   <= qs;
         se_ff   <= qe;
         view_ff <= view_in;
         dpos_ff <= tag_ff[DIV_LAT-1][0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_x        = px_ff;
   assign rsp_pixel_y        = py_ff;
   assign rsp_span_start     = ss_ff;
   assign rsp_span_end       = se_ff;
   assign rsp_in_view        = view_ff;
   assign rsp_depth_positive = dpos_ff;

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");
   a_nodepth_noview: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_depth_positive |-> !rsp_in_view)
      else $error("in_view set without positive depth");
   a_nodepth_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_depth_positive |-> rsp_pixel_x == 16'sd32767 &&
      rsp_pixel_y == 16'sd32767 && rsp_span_start == 16'sd32767)
      else $error("fields not saturated for nonpositive depth");
   a_view_border: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_view |-> rsp_pixel_x >= 16'sd2 && rsp_pixel_y >= 16'sd2)
      else $error("in_view set for a pixel on the border");
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while output is free");
`endif

endmodule

>>> rtl/lbcp_cordic_cell.sv
// One rotation step of the vectoring-free CORDIC chain.
// Depends on lbcp_pkg for the item type and the arctangent table.
module lbcp_cordic_cell
   import lbcp_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       in_valid,
   input  cordic_type in_data,
   output logic       out_valid,
   output cordic_type out_data
);

   logic       valid_ff;
   cordic_type data_ff, data_in;
   logic signed [XW-1:0] dx, dy;

   always_comb begin
      dx = in_data.y >>> STEP;
      dy = in_data.x >>> STEP;
      data_in = in_data;
      if (in_data.r >= 0) begin
         data_in.x = in_data.x - dx;
         data_in.y = in_data.y + dy;
         data_in.r = in_data.r - atan_of(STEP);
      end else begin
         data_in.x = in_data.x + dx;
         data_in.y = in_data.y - dy;
         data_in.r = in_data.r + atan_of(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/lbcp_divider.sv
// Pipelined restoring divider, one quotient bit per stage, saturated to 16 bits.
// Depends on lbcp_pkg for widths. FLOOR selects floor or truncation.
module lbcp_divider
   import lbcp_pkg::*;
#(
   parameter bit FLOOR = 1'b1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [NW-1:0] num,
   input  logic [DW-1:0]        den,
   input  logic                 force_max,
   output logic                 out_valid,
   output logic signed [15:0]   quot
);

   localparam int RW = DW + QB;

   logic [RW-1:0]  rem_ff [0:QB];
   logic [DW-1:0]  den_ff [0:QB];
   logic [QB-1:0]  q_ff   [0:QB];
   logic           neg_ff [0:QB];
   logic           over_ff [0:QB];
   logic           frc_ff [0:QB];
   logic           v_ff   [0:QB];
   logic           vo_ff;
   logic signed [15:0] quot_ff, quot_in;
   logic [NW-1:0]  mag;
   logic [RW-1:0]  rem0;
   logic [QB:0]    qmag;

   always_comb begin
      mag  = num[NW-1] ? NW'(-num) : NW'(num);
      rem0 = RW'(mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem0;
         den_ff[0]  <= den;
         q_ff[0]    <= '0;
         neg_ff[0]  <= num[NW-1];
         over_ff[0] <= rem0 >= {den, {QB{1'b0}}};
         frc_ff[0]  <= force_max;
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_stage
      logic [RW-1:0] sub;
      logic          take;
      assign sub  = RW'(den_ff[k-1]) << (QB - k);
      assign take = rem_ff[k-1] >= sub;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? rem_ff[k-1] - sub : rem_ff[k-1];
            q_ff[k]    <= {q_ff[k-1][QB-2:0], take};
            den_ff[k]  <= den_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            over_ff[k] <= over_ff[k-1];
            frc_ff[k]  <= frc_ff[k-1];
         end
      end
   end

   always_comb begin
      // round magnitude up for floor of a negative inexact quotient
      qmag = {1'b0, q_ff[QB]} +
             (QB+1)'(FLOOR && neg_ff[QB] && (rem_ff[QB] != '0));
      if (frc_ff[QB]) begin
         quot_in = 16'(SAT_HI);
      end else if (neg_ff[QB]) begin
         if (over_ff[QB] || qmag > (QB+1)'(32768)) begin
            quot_in = 16'sh8000;
         end else begin
            quot_in = 16'(-$signed({1'b0, qmag}));
         end
      end else begin
         if (over_ff[QB] || qmag > (QB+1)'(SAT_HI)) begin
            quot_in = 16'(SAT_HI);
         end else begin
            quot_in = 16'(qmag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= v_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
      end
   end

   assign out_valid = vo_ff;
   assign quot      = quot_ff;

endmodule

>>> verif/lidar_beam_camera_projection_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lidar_beam_camera_projection: drives beams and CSR writes,
// predicts every result in a scoreboard class and compares field by field.
// Depends on lbcp_pkg and the lidar_beam_camera_projection RTL.
module lidar_beam_camera_projection_tb;
   import lbcp_pkg::*;

   typedef struct {
      logic signed [15:0] pixel_x;
      logic signed [15:0] pixel_y;
      logic signed [15:0] span_start;
      logic signed [15:0] span_end;
      logic               in_view;
      logic               depth_positive;
   } pixel_result_t;

   class projection_scoreboard;
      longint start_angle;
      longint angle_step, focal_length, center_x, center_y;
      longint image_width, image_height, max_range;
      longint arctan_q20[20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                                 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
      pixel_result_t expected_pixels[$];

      function void load_defaults();
         start_angle = -3294199;
         angle_step = 18300;
         focal_length = 7627;
         center_x = 6408;
         center_y = 6408;
         image_width = 200;
         image_height = 200;
         max_range = 5120;
      endfunction

      function void write_reg(logic [3:0] idx, logic [22:0] data);
         case (idx)
            REG_START_ANGLE:  start_angle = longint'($signed(data));
            REG_ANGLE_STEP:   angle_step = longint'(data[17:0]);
            REG_FOCAL_LENGTH: focal_length = longint'(data[15:0]);
            REG_CENTER_X:     center_x = longint'(data[15:0]);
            REG_CENTER_Y:     center_y = longint'(data[15:0]);
            REG_IMAGE_WIDTH:  image_width = longint'(data[11:0]);
            REG_IMAGE_HEIGHT: image_height = longint'(data[11:0]);
            REG_MAX_RANGE:    max_range = longint'(data[15:0]);
            default: ;
         endcase
      endfunction

      function logic signed [15:0] sat16(longint v);
         if (v > 32767) return 16'sd32767;
         if (v < -32768) return -16'sd32768;
         return v[15:0];
      endfunction

      function longint floor_div(longint n, longint d);
         longint q;
         q = n / d;
         if ((n % d) != 0 && n < 0) q -= 1;
         return q;
      endfunction

      // Row of a point raised by h; saturate high when it sits behind the camera.
      function longint span_row(longint h, longint lz);
         longint z, y;
         z = (-longint'(SIN_Q20) * h + longint'(COS_Q20) * lz) >>> 20;
         y = ((longint'(COS_Q20) * h - longint'(SIN_Q20) * lz) >>> 20) - OFF_Q16;
         if (z <= 0) return SAT_HI;
         return (focal_length * y + center_y * z) / (16 * z);
      endfunction

      function void note_beam(logic [8:0] idx, logic [15:0] rng);
         longint theta, r, x, y, dx, dy, lx, lz, z0, y0, px, py;
         logic neg;
         pixel_result_t res;
         neg = 0;
         theta = start_angle + (longint'(idx) + 180) * angle_step;
         r = theta % TWO_PI_Q;
         if (r < 0) r += TWO_PI_Q;
         if (r > PI_Q) r -= TWO_PI_Q;
         if (r > HALF_PI_Q) begin
            r -= PI_Q;
            neg = 1;
         end else if (r < -HALF_PI_Q) begin
            r += PI_Q;
            neg = 1;
         end
         x = ((longint'(rng) << 8) * longint'(KINV_Q30) + (64'sd1 << 29)) >>> 30;
         y = 0;
         for (int i = 0; i < 20; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0) begin
               x -= dx;
               y += dy;
               r -= arctan_q20[i];
            end else begin
               x += dx;
               y -= dy;
               r += arctan_q20[i];
            end
         end
         if (neg) begin
            x = -x;
            y = -y;
         end
         lz = x;
         lx = -y;
         z0 = (longint'(COS_Q20) * lz) >>> 20;
         y0 = ((-longint'(SIN_Q20) * lz) >>> 20) - OFF_Q16;
         res.depth_positive = z0 > 0;
         if (z0 > 0) begin
            px = floor_div(focal_length * lx + center_x * z0, 16 * z0);
            py = floor_div(focal_length * y0 + center_y * z0, 16 * z0);
            res.pixel_x = sat16(px);
            res.pixel_y = sat16(py);
            res.span_start = sat16(span_row(OFF_Q16, lz));
            res.span_end = sat16(span_row(-longint'(OFF_Q16), lz));
            res.in_view = rng < max_range && px >= 2 && px < image_width - 2 &&
                          py >= 2 && py < image_height - 2;
         end else begin
            res.pixel_x = 16'(SAT_HI);
            res.pixel_y = 16'(SAT_HI);
            res.span_start = 16'(SAT_HI);
            res.span_end = 16'(SAT_HI);
            res.in_view = 0;
         end
         expected_pixels.push_back(res);
      endfunction

      // Return an empty string on a match, else a description of the mismatch.
      function string check_result(pixel_result_t got);
         pixel_result_t exp_r;
         if (expected_pixels.size() == 0) return "result with no item outstanding";
         exp_r = expected_pixels.pop_front();
         if (got.pixel_x !== exp_r.pixel_x || got.pixel_y !== exp_r.pixel_y ||
             got.span_start !== exp_r.span_start || got.span_end !== exp_r.span_end ||
             got.in_view !== exp_r.in_view || got.depth_positive !== exp_r.depth_positive)
            return $sformatf("got px %0d py %0d ss %0d se %0d v %0b d %0b, want %0d %0d %0d %0d %0b %0b",
               got.pixel_x, got.pixel_y, got.span_start, got.span_end, got.in_view,
               got.depth_positive, exp_r.pixel_x, exp_r.pixel_y, exp_r.span_start,
               exp_r.span_end, exp_r.in_view, exp_r.depth_positive);
         return "";
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [8:0] req_beam_index = '0;
   logic [15:0] req_range_value = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [15:0] rsp_pixel_x, rsp_pixel_y, rsp_span_start, rsp_span_end;
   logic rsp_in_view, rsp_depth_positive;
   logic csr_valid = 0;
   logic csr_ready;
   logic [3:0] csr_index = '0;
   logic [22:0] csr_wdata = '0;

   projection_scoreboard sb = new();
   int error_count = 0;
   int cycle_count = 0;
   bit no_idle = 0;
   int stall_left = 0;

   lidar_beam_camera_projection u_dut (.*);

   always #1 clock = ~clock;

   task automatic report(string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (no_idle || pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 1000000) begin
         $display("lidar_beam_camera_projection_tb: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      pixel_result_t got;
      string msg;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.pixel_x = rsp_pixel_x;
         got.pixel_y = rsp_pixel_y;
         got.span_start = rsp_span_start;
         got.span_end = rsp_span_end;
         got.in_view = rsp_in_view;
         got.depth_positive = rsp_depth_positive;
         msg = sb.check_result(got);
         if (msg != "") report(msg);
      end
   end

   // Receiver back-pressure.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1;
      end else begin
         stall_left = gap_len();
         rsp_stall = stall_left > 0;
         if (stall_left > 0) stall_left--;
      end
   end

   task automatic send_beam(logic [8:0] idx, logic [15:0] rng);
      int gap;
      gap = gap_len();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 0;
         @(posedge clock);
      end
      @(negedge clock);
      req_valid = 1;
      req_beam_index = idx;
      req_range_value = rng;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_beam(idx, rng);
   endtask

   task automatic write_csr(logic [3:0] idx, logic [22:0] data);
      @(negedge clock);
      req_valid = 0;
      csr_valid = 1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (sb.expected_pixels.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic random_beams(int count);
      logic [8:0] idx;
      logic [15:0] rng;
      for (int n = 0; n < count; n++) begin
         idx = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, 359));
         case ($urandom_range(0, 3))
            0: rng = 16'($urandom);
            1: rng = 16'($urandom_range(0, 255));
            default: rng = 16'($urandom_range(64, 5119));
         endcase
         send_beam(idx, rng);
      end
   endtask

   initial begin
      sb.load_defaults();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: field extremes, straight ahead, behind the camera, beyond the scan.
      send_beam(9'd0, 16'd0);
      send_beam(9'd0, 16'hFFFF);
      send_beam(9'd0, 16'd5119);
      send_beam(9'd0, 16'd5120);
      send_beam(9'd0, 16'd256);
      send_beam(9'd45, 16'd1024);
      send_beam(9'd315, 16'd1024);
      send_beam(9'd90, 16'd1024);
      send_beam(9'd270, 16'd1024);
      send_beam(9'd180, 16'd1024);
      send_beam(9'd179, 16'd1);
      send_beam(9'd359, 16'd2000);
      send_beam(9'd360, 16'd2000);
      send_beam(9'd511, 16'hFFFF);
      send_beam(9'd85, 16'd300);
      send_beam(9'd95, 16'd300);
      send_beam(9'd10, 16'd40);
      send_beam(9'd350, 16'd40);
      send_beam(9'h155, 16'h5555);
      send_beam(9'h0AA, 16'hAAAA);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: ;
            1: begin
               write_csr(REG_START_ANGLE, 23'h400000);
               write_csr(REG_ANGLE_STEP, 23'h3FFFF);
               write_csr(REG_FOCAL_LENGTH, 23'hFFFF);
               write_csr(REG_CENTER_X, 23'd0);
               write_csr(REG_CENTER_Y, 23'hFFFF);
               write_csr(REG_IMAGE_WIDTH, 23'd5);
               write_csr(REG_IMAGE_HEIGHT, 23'd4095);
               write_csr(REG_MAX_RANGE, 23'hFFFF);
               write_csr(4'd8, 23'h7FFFFF);
               write_csr(4'd15, 23'd0);
            end
            2: begin
               write_csr(REG_START_ANGLE, 23'h3FFFFF);
               write_csr(REG_ANGLE_STEP, 23'd0);
               write_csr(REG_FOCAL_LENGTH, 23'd0);
               write_csr(REG_CENTER_X, 23'hFFFF);
               write_csr(REG_CENTER_Y, 23'd0);
               write_csr(REG_IMAGE_WIDTH, 23'd4095);
               write_csr(REG_IMAGE_HEIGHT, 23'd5);
               write_csr(REG_MAX_RANGE, 23'd0);
            end
            3: begin
               write_csr(REG_START_ANGLE, 23'(-3294199));
               write_csr(REG_ANGLE_STEP, 23'd18300);
               write_csr(REG_FOCAL_LENGTH, 23'd7627);
               write_csr(REG_CENTER_X, 23'd6408);
               write_csr(REG_CENTER_Y, 23'd6408);
               write_csr(REG_IMAGE_WIDTH, 23'd3);
               write_csr(REG_IMAGE_HEIGHT, 23'd200);
               write_csr(REG_MAX_RANGE, 23'd5120);
            end
            default: begin
               write_csr(REG_START_ANGLE, 23'($urandom));
               write_csr(REG_ANGLE_STEP, 23'($urandom_range(0, 40000)));
               write_csr(REG_FOCAL_LENGTH, 23'($urandom_range(1000, 20000)));
               write_csr(REG_CENTER_X, 23'($urandom_range(0, 65535)));
               write_csr(REG_CENTER_Y, 23'($urandom_range(0, 65535)));
               write_csr(REG_IMAGE_WIDTH, 23'($urandom_range(5, 4095)));
               write_csr(REG_IMAGE_HEIGHT, 23'($urandom_range(5, 4095)));
               write_csr(REG_MAX_RANGE, 23'($urandom_range(0, 65535)));
            end
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         random_beams(305);
         no_idle = 0;
         drain();
      end

      if (sb.expected_pixels.size() != 0)
         report($sformatf("%0d results never arrived", sb.expected_pixels.size()));
      if (error_count == 0)
         $display("lidar_beam_camera_projection_tb: clean");
      else
         $display("lidar_beam_camera_projection_tb: errors");
      $finish;
   end
endmodule
